>>> design/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types, constants and helpers for the character display controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd_pkg;

  localparam int OpcodeW   = 3;
  localparam int CharW     = 8;
  localparam int TRowW     = 3;
  localparam int TColW     = 5;
  localparam int NibbleW   = 4;
  localparam int BaseW     = 7;
  localparam int CfgIdxW   = 2;
  localparam int RowW      = 2;
  localparam int SeqCntW   = 4;
  localparam int JobBytes  = 4;
  localparam int ByteIdxW  = 2;

  localparam int DefColumns    = 20;
  localparam int DefRows       = 4;
  localparam int DefQueueDepth = 2;

  localparam logic [BaseW-1:0] Row0BaseRst = 7'h00;
  localparam logic [BaseW-1:0] Row1BaseRst = 7'h40;
  localparam logic [BaseW-1:0] Row2BaseRst = 7'h14;
  localparam logic [BaseW-1:0] Row3BaseRst = 7'h54;

  localparam logic [7:0]         CmdClear   = 8'h01;
  localparam logic [7:0]         CharSpace  = 8'h20;
  localparam logic [SeqCntW-1:0] InitLast   = 4'd13;

  typedef enum logic [OpcodeW-1:0] {
    OP_INIT   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_DELETE = 3'd2,
    OP_MOVE   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0_BASE = 2'd0,
    REG_ROW1_BASE = 2'd1,
    REG_ROW2_BASE = 2'd2,
    REG_ROW3_BASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_BYTES,
    JOB_REJECT
  } job_kind_e;

  typedef struct packed {
    job_kind_e                  kind;
    logic [ByteIdxW-1:0]        last_byte;
    logic [JobBytes-1:0]        rs;
    logic [JobBytes-1:0][7:0]   bytes;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

  function automatic logic [7:0] set_addr(logic [BaseW-1:0] base, logic [BaseW-1:0] col);
    logic [BaseW-1:0] sum;
    sum = base + col;
    return {1'b1, sum};
  endfunction

  function automatic logic [NibbleW-1:0] init_nibble(logic [SeqCntW-1:0] idx);
    logic [NibbleW-1:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2:  nib = 4'h3;
      4'd3, 4'd4:        nib = 4'h2;
      4'd5, 4'd7:        nib = 4'h8;
      4'd9:              nib = 4'h1;
      4'd11:             nib = 4'h6;
      4'd13:             nib = 4'hF;
      default:           nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

`default_nettype wire

>>> design/lcd_ifs.sv
// ----------------------------------------------------------------------------
// lcd channel interfaces
// Valid/ready channels for operations, bus results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcd_op_if;
  import lcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [OpcodeW-1:0] opcode;
  logic [CharW-1:0]   char_code;
  logic [TRowW-1:0]   target_row;
  logic [TColW-1:0]   target_column;
  modport source (output valid, opcode, char_code, target_row, target_column, input ready);
  modport sink   (input valid, opcode, char_code, target_row, target_column, output ready);
endinterface

interface lcd_res_if;
  import lcd_pkg::*;
  logic               valid;
  logic               ready;
  logic               bus_valid;
  logic               reg_select;
  logic [NibbleW-1:0] nibble;
  logic               status;
  logic               last;
  modport source (output valid, bus_valid, reg_select, nibble, status, last, input ready);
  modport sink   (input valid, bus_valid, reg_select, nibble, status, last, output ready);
endinterface

interface lcd_cfg_if;
  import lcd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [BaseW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/char_lcd_cursor_controller.sv
// An op's job is registered in the queue, then its first beat in the result stage.
// Throughput: one result beat per cycle while the output is ready; an op yields
// 1 beat for a rejection, 2 to 8 for edits and moves and 14 for init.
// Ops are taken while the queue has room, so fronts and back overlap.
// Reset: cursor at row 0 column 0, row bases at defaults, queue and output empty.
// ----------------------------------------------------------------------------
// char_lcd_cursor_controller
// 4-bit character display front end with cursor tracking and row wrap.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_cursor_controller #(
  parameter int COLUMNS     = lcd_pkg::DefColumns,
  parameter int ROWS        = lcd_pkg::DefRows,
  parameter int QUEUE_DEPTH = lcd_pkg::DefQueueDepth
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  lcd_op_if.sink    op_i,
  lcd_cfg_if.sink   cfg_i,
  lcd_res_if.source res_o
);
  import lcd_pkg::*;

  logic  push, full, pop;
  job_t  push_job;
  head_t head;

  lcd_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_i),
    .cfg_i      (cfg_i),
    .q_full_i   (full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  lcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head)
  );

  lcd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

>>> design/lcd_front.sv
// ----------------------------------------------------------------------------
// lcd_front
// Takes operation beats, tracks the cursor and turns each operation into a
// sequencer job: init, reject or command/data bytes. Holds row base registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_front #(
  parameter int COLUMNS = lcd_pkg::DefColumns,
  parameter int ROWS    = lcd_pkg::DefRows
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  lcd_op_if.sink        op_i,
  lcd_cfg_if.sink       cfg_i,
  input  wire           q_full_i,
  output logic          push_o,
  output lcd_pkg::job_t push_job_o
);
  import lcd_pkg::*;

  localparam int ColW = $clog2(COLUMNS);
  localparam logic [ColW-1:0] LastCol = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0] LastRow = RowW'(ROWS - 1);

  logic [BaseW-1:0] base0_q, base1_q, base2_q, base3_q;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  next_row, prev_row;
  logic [BaseW-1:0] col7, last_col7;
  logic [7:0]       addr_a, addr_b;
  logic             move_bad;
  job_t             job;

  function automatic logic [BaseW-1:0] pick(logic [RowW-1:0] r, logic [BaseW-1:0] b0,
                                            logic [BaseW-1:0] b1, logic [BaseW-1:0] b2,
                                            logic [BaseW-1:0] b3);
    logic [BaseW-1:0] b;
    case (r)
      2'd0:    b = b0;
      2'd1:    b = b1;
      2'd2:    b = b2;
      default: b = b3;
    endcase
    return b;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign op_i.ready  = !q_full_i;
  assign push_o      = op_i.valid && !q_full_i;
  assign push_job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base0_q <= Row0BaseRst;
      base1_q <= Row1BaseRst;
      base2_q <= Row2BaseRst;
      base3_q <= Row3BaseRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_ROW0_BASE: base0_q <= cfg_i.data;
        REG_ROW1_BASE: base1_q <= cfg_i.data;
        REG_ROW2_BASE: base2_q <= cfg_i.data;
        REG_ROW3_BASE: base3_q <= cfg_i.data;
        default:       base0_q <= base0_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (push_o) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_comb begin
    next_row  = (row_q == LastRow) ? '0 : row_q + 1'b1;
    prev_row  = row_q - 1'b1;
    col7      = BaseW'(col_q);
    last_col7 = BaseW'(LastCol);
    move_bad  = (32'(op_i.target_row) >= ROWS) || (32'(op_i.target_column) >= COLUMNS);

    job           = '0;
    job.kind      = JOB_REJECT;
    row_d         = row_q;
    col_d         = col_q;
    addr_a        = '0;
    addr_b        = '0;

    case (op_i.opcode)
      OP_INIT: begin
        job.kind = JOB_INIT;
        row_d    = '0;
        col_d    = '0;
      end
      OP_WRITE: begin
        job.kind     = JOB_BYTES;
        job.bytes[0] = op_i.char_code;
        job.rs[0]    = 1'b1;
        if (col_q == LastCol) begin
          addr_a       = set_addr(pick(next_row, base0_q, base1_q, base2_q, base3_q), '0);
          job.bytes[1] = addr_a;
          job.last_byte = 2'd1;
          row_d        = next_row;
          col_d        = '0;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      OP_DELETE: begin
        if (row_q == '0 && col_q == '0) begin
          job.kind = JOB_REJECT;
        end else if (col_q == '0) begin
          addr_a        = set_addr(pick(prev_row, base0_q, base1_q, base2_q, base3_q),
                                   last_col7);
          addr_b        = set_addr(pick(row_q, base0_q, base1_q, base2_q, base3_q), '0);
          job.kind      = JOB_BYTES;
          job.bytes     = {addr_a, addr_b, CharSpace, addr_a};
          job.rs        = 4'b0010;
          job.last_byte = 2'd3;
          row_d         = prev_row;
          col_d         = LastCol;
        end else begin
          addr_a        = set_addr(pick(row_q, base0_q, base1_q, base2_q, base3_q),
                                   col7 - 1'b1);
          job.kind      = JOB_BYTES;
          job.bytes     = {8'h00, addr_a, CharSpace, addr_a};
          job.rs        = 4'b0010;
          job.last_byte = 2'd2;
          col_d         = col_q - 1'b1;
        end
      end
      OP_MOVE: begin
        if (!move_bad) begin
          addr_a       = set_addr(pick(RowW'(op_i.target_row), base0_q, base1_q, base2_q,
                                       base3_q), BaseW'(op_i.target_column));
          job.kind     = JOB_BYTES;
          job.bytes[0] = addr_a;
          row_d        = RowW'(op_i.target_row);
          col_d        = ColW'(op_i.target_column);
        end
      end
      OP_CLEAR: begin
        job.kind     = JOB_BYTES;
        job.bytes[0] = CmdClear;
      end
      default: job.kind = JOB_REJECT;
    endcase
  end

endmodule

`default_nettype wire

>>> design/lcd_queue.sv
// ----------------------------------------------------------------------------
// lcd_queue
// Short job queue between the front end and the nibble sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_queue #(
  parameter int DEPTH = lcd_pkg::DefQueueDepth
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  lcd_pkg::job_t  push_job_i,
  output logic           full_o,
  input  wire            pop_i,
  output lcd_pkg::head_t head_o
);
  import lcd_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

>>> design/lcd_back.sv
// ----------------------------------------------------------------------------
// lcd_back
// Walks the head job one nibble per beat into a registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_back (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  lcd_pkg::head_t head_i,
  output logic           pop_o,
  lcd_res_if.source      res_o
);
  import lcd_pkg::*;

  logic [SeqCntW-1:0]  cnt_q, cnt_d;
  logic                vld_q;
  logic                bus_q, rs_q, status_q, last_q;
  logic [NibbleW-1:0]  nib_q;
  logic                bus_c, rs_c, status_c, last_c;
  logic [NibbleW-1:0]  nib_c;
  logic [ByteIdxW-1:0] bidx;
  logic [7:0]          cur_byte;
  logic                load;

  assign res_o.valid      = vld_q;
  assign res_o.bus_valid  = bus_q;
  assign res_o.reg_select = rs_q;
  assign res_o.nibble     = nib_q;
  assign res_o.status     = status_q;
  assign res_o.last       = last_q;

  assign load  = head_i.valid && (!vld_q || res_o.ready);
  assign pop_o = load && last_c;

  always_comb begin
    bidx     = cnt_q[ByteIdxW:1];
    cur_byte = head_i.job.bytes[bidx];
    bus_c    = 1'b1;
    rs_c     = 1'b0;
    status_c = 1'b0;
    nib_c    = '0;
    last_c   = 1'b0;
    case (head_i.job.kind)
      JOB_INIT: begin
        nib_c  = init_nibble(cnt_q);
        last_c = (cnt_q == InitLast);
      end
      JOB_BYTES: begin
        nib_c  = cnt_q[0] ? cur_byte[3:0] : cur_byte[7:4];
        rs_c   = head_i.job.rs[bidx];
        last_c = cnt_q[0] && (bidx == head_i.job.last_byte);
      end
      default: begin
        bus_c    = 1'b0;
        status_c = 1'b1;
        last_c   = 1'b1;
      end
    endcase
    cnt_d = last_c ? '0 : cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        cnt_q <= cnt_d;
      end else if (res_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bus_q    <= bus_c;
      rs_q     <= rs_c;
      nib_q    <= nib_c;
      status_q <= status_c;
      last_q   <= last_c;
    end
  end

endmodule

`default_nettype wire

>>> design/lcd_checker.sv
// ----------------------------------------------------------------------------
// lcd_checker
// Port-level checks on the result channel of the display controller.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       res_valid_i,
  input wire       res_ready_i,
  input wire       res_bus_valid_i,
  input wire       res_reg_select_i,
  input wire [3:0] res_nibble_i,
  input wire       res_status_i,
  input wire       res_last_i
);

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i |-> res_last_i && !res_bus_valid_i && !res_reg_select_i &&
                                    (res_nibble_i == 4'h0))
    else $error("rejected beat malformed");

  a_bus_vs_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (res_bus_valid_i != res_status_i))
    else $error("bus_valid and status disagree");

  a_data_drives_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_reg_select_i |-> res_bus_valid_i && !res_status_i)
    else $error("data beat without bus drive");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_nibble_i) &&
                                    $stable(res_last_i))
    else $error("stalled result beat changed");

endmodule

bind char_lcd_cursor_controller lcd_checker u_lcd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_bus_valid_i  (res_o.bus_valid),
  .res_reg_select_i (res_o.reg_select),
  .res_nibble_i     (res_o.nibble),
  .res_status_i     (res_o.status),
  .res_last_i       (res_o.last)
);

`default_nettype wire

>>> sim/tb_char_lcd_cursor_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_cursor_controller
// Drives display operations and row base writes into the controller and checks
// every bus beat against a cursor-tracking prediction of the nibble sequence.
// The run covers a directed pass over the edge cases, then randomized phases
// under several row base settings, mostly with random idling on both channels.
// ----------------------------------------------------------------------------

module tb_char_lcd_cursor_controller;
  import lcd_pkg::*;

  localparam int Columns        = DefColumns;
  localparam int Rows           = DefRows;
  localparam int LongHoldCycles = 60;
  localparam int DrainCycles    = 20;
  localparam int MaxReports     = 100;
  localparam int PhaseItems     = 96;

  localparam logic [7:0] SetAddr     = 8'h80;
  localparam logic [7:0] FunctionSet = 8'h28;
  localparam logic [7:0] DisplayOff  = 8'h08;
  localparam logic [7:0] EntryMode   = 8'h06;
  localparam logic [7:0] DisplayOn   = 8'h0F;

  localparam logic [NibbleW-1:0] WakeNib    = 4'h3;
  localparam logic [NibbleW-1:0] FourBitNib = 4'h2;

  localparam logic [OpcodeW-1:0] OpBadFirst = 3'd5;
  localparam logic [OpcodeW-1:0] OpBadLast  = 3'd7;

  localparam logic [BaseW-1:0] BaseMax = 7'h7F;
  localparam logic [BaseW-1:0] BaseMin = 7'h00;

  typedef struct packed {
    logic               bus_valid;
    logic               reg_select;
    logic [NibbleW-1:0] nibble;
    logic               status;
    logic               last;
  } lcd_beat_t;

  class lcd_nibble_board;
    lcd_beat_t        pending_nibbles[$];
    logic [BaseW-1:0] row_base [Rows];
    logic [RowW-1:0]  cur_row;
    logic [TColW-1:0] cur_col;
    int               errors;
    int               ops;
    int               beats;
    int               rejects;
    int               wraps;

    function new();
      row_base = '{Row0BaseRst, Row1BaseRst, Row2BaseRst, Row3BaseRst};
      cur_row  = '0;
      cur_col  = '0;
      errors   = 0;
      ops      = 0;
      beats    = 0;
      rejects  = 0;
      wraps    = 0;
    endfunction

    function void set_base(int idx, logic [BaseW-1:0] val);
      row_base[idx] = val;
    endfunction

    function int outstanding();
      return pending_nibbles.size();
    endfunction

    function void push_nibble(logic rs, logic [NibbleW-1:0] nib);
      lcd_beat_t b;
      b = {1'b1, rs, nib, 1'b0, 1'b0};
      pending_nibbles.push_back(b);
    endfunction

    function void push_byte(logic rs, logic [7:0] val);
      push_nibble(rs, val[7:4]);
      push_nibble(rs, val[3:0]);
    endfunction

    function void push_reject();
      lcd_beat_t b;
      b = {1'b0, 1'b0, 4'h0, 1'b1, 1'b0};
      pending_nibbles.push_back(b);
      rejects++;
    endfunction

    function void seek(logic [RowW-1:0] r, logic [TColW-1:0] c);
      logic [BaseW-1:0] addr;
      addr = row_base[r] + BaseW'(c);
      push_byte(1'b0, SetAddr | {1'b0, addr});
      cur_row = r;
      cur_col = c;
    endfunction

    function void put_char(logic [7:0] ch);
      push_byte(1'b1, ch);
      cur_col = cur_col + 1'b1;
      if (cur_col >= Columns) begin
        wraps++;
        seek(RowW'((int'(cur_row) + 1) % Rows), '0);
      end
    endfunction

    // predict the bus beats of one accepted operation
    function void note_op(logic [OpcodeW-1:0] opc, logic [CharW-1:0] ch,
                          logic [TRowW-1:0] tr, logic [TColW-1:0] tc);
      lcd_beat_t        tail;
      logic [RowW-1:0]  r;
      logic [TColW-1:0] c;
      ops++;
      case (opc)
        OP_INIT: begin
          cur_row = '0;
          cur_col = '0;
          push_nibble(1'b0, WakeNib);
          push_nibble(1'b0, WakeNib);
          push_nibble(1'b0, WakeNib);
          push_nibble(1'b0, FourBitNib);
          push_byte(1'b0, FunctionSet);
          push_byte(1'b0, DisplayOff);
          push_byte(1'b0, CmdClear);
          push_byte(1'b0, EntryMode);
          push_byte(1'b0, DisplayOn);
        end
        OP_WRITE: put_char(ch);
        OP_DELETE: begin
          if (cur_row == '0 && cur_col == '0) begin
            push_reject();
          end else begin
            if (cur_col == '0) begin
              r = cur_row - 1'b1;
              c = TColW'(Columns - 1);
            end else begin
              r = cur_row;
              c = cur_col - 1'b1;
            end
            seek(r, c);
            put_char(CharSpace);
            seek(r, c);
          end
        end
        OP_MOVE: begin
          if (tr >= Rows || tc >= Columns) begin
            push_reject();
          end else begin
            seek(tr[RowW-1:0], tc);
          end
        end
        OP_CLEAR: push_byte(1'b0, CmdClear);
        default: push_reject();
      endcase
      tail = pending_nibbles.pop_back();
      tail.last = 1'b1;
      pending_nibbles.push_back(tail);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
    endtask

    task check_nibble(lcd_beat_t got);
      lcd_beat_t want;
      if (pending_nibbles.size() == 0) begin
        report($sformatf("result beat %h with nothing outstanding", got));
      end else begin
        want = pending_nibbles.pop_front();
        beats++;
        if (got.bus_valid !== want.bus_valid)
          report($sformatf("bus_valid %b, want %b", got.bus_valid, want.bus_valid));
        if (got.reg_select !== want.reg_select)
          report($sformatf("reg_select %b, want %b", got.reg_select, want.reg_select));
        if (got.nibble !== want.nibble)
          report($sformatf("nibble %h, want %h", got.nibble, want.nibble));
        if (got.status !== want.status)
          report($sformatf("status %b, want %b", got.status, want.status));
        if (got.last !== want.last)
          report($sformatf("last %b, want %b", got.last, want.last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  bit   hold_req;
  int   settings;

  lcd_nibble_board board = new();

  lcd_op_if  op_if ();
  lcd_cfg_if cfg_if ();
  lcd_res_if res_if ();

  char_lcd_cursor_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("tb_char_lcd_cursor_controller: errors");
    $finish;
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      board.check_nibble({res_if.bus_valid, res_if.reg_select, res_if.nibble,
                          res_if.status, res_if.last});
    end
  end

  task automatic send_op(logic [OpcodeW-1:0] opc, logic [CharW-1:0] ch,
                         logic [TRowW-1:0] tr, logic [TColW-1:0] tc);
    op_if.valid         <= 1'b1;
    op_if.opcode        <= opc;
    op_if.char_code     <= ch;
    op_if.target_row    <= tr;
    op_if.target_column <= tc;
    do @(posedge clk_i); while (!op_if.ready);
    board.note_op(opc, ch, tr, tc);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      op_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic pause_until_drained();
    op_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic program_bases(logic [BaseW-1:0] b0, logic [BaseW-1:0] b1,
                               logic [BaseW-1:0] b2, logic [BaseW-1:0] b3);
    logic [BaseW-1:0] vals [Rows];
    vals = '{b0, b1, b2, b3};
    pause_until_drained();
    for (int i = 0; i < Rows; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= cfg_idx_e'(i);
      cfg_if.data  <= vals[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      board.set_base(i, vals[i]);
    end
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // mostly edits and moves near the row end, so wraps and deletes at column 0 occur
  task automatic random_op();
    int                 pick;
    logic [OpcodeW-1:0] opc;
    logic [CharW-1:0]   ch;
    logic [TRowW-1:0]   tr;
    logic [TColW-1:0]   tc;
    ch   = $urandom_range(0, 255);
    tr   = $urandom_range(0, 7);
    tc   = $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      opc = OP_WRITE;
    end else if (pick < 55) begin
      opc = OP_DELETE;
    end else if (pick < 75) begin
      opc = OP_MOVE;
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 1) begin
          tr = $urandom_range(Rows, 7);
        end else begin
          tr = $urandom_range(0, Rows - 1);
          tc = $urandom_range(Columns, 31);
        end
      end else begin
        tr = $urandom_range(0, Rows - 1);
        case ($urandom_range(0, 3))
          0: tc = TColW'(Columns - 1);
          1: tc = '0;
          default: tc = $urandom_range(0, Columns - 1);
        endcase
      end
    end else if (pick < 85) begin
      opc = OP_CLEAR;
    end else if (pick < 93) begin
      opc = OP_INIT;
    end else begin
      opc = $urandom_range(OpBadFirst, OpBadLast);
    end
    send_op(opc, ch, tr, tc);
  endtask

  task automatic run_items(int n, bit mid_pause);
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) pause_until_drained();
      random_op();
    end
  endtask

  initial begin
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    settings            = 1;
    rst_ni              = 1'b0;
    op_if.valid         = 1'b0;
    op_if.opcode        = OP_INIT;
    op_if.char_code     = '0;
    op_if.target_row    = '0;
    op_if.target_column = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_ROW0_BASE;
    cfg_if.data         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_op(OP_INIT, 8'h00, 3'd0, 5'd0);
    send_op(OP_WRITE, 8'h00, 3'd7, 5'd31);
    send_op(OP_WRITE, 8'hFF, 3'd0, 5'd0);
    send_op(OP_DELETE, 8'h00, 3'd0, 5'd0);
    send_op(OP_DELETE, 8'h00, 3'd0, 5'd0);
    send_op(OP_DELETE, 8'h00, 3'd0, 5'd0);
    send_op(OP_MOVE, 8'h00, 3'd0, 5'd19);
    send_op(OP_WRITE, 8'h41, 3'd0, 5'd0);
    send_op(OP_DELETE, 8'h00, 3'd0, 5'd0);
    send_op(OP_MOVE, 8'h00, 3'd3, 5'd19);
    send_op(OP_WRITE, 8'h7E, 3'd0, 5'd0);
    send_op(OP_MOVE, 8'h00, 3'd3, 5'd0);
    send_op(OP_DELETE, 8'h00, 3'd0, 5'd0);
    send_op(OP_MOVE, 8'h00, 3'd4, 5'd0);
    send_op(OP_MOVE, 8'h00, 3'd0, 5'd20);
    send_op(OP_MOVE, 8'h00, 3'd7, 5'd31);
    send_op(OP_CLEAR, 8'h00, 3'd0, 5'd0);
    for (int o = OpBadFirst; o <= OpBadLast; o++) begin
      send_op(OpcodeW'(o), 8'h00, 3'd0, 5'd0);
    end
    send_op(OP_MOVE, 8'h00, 3'd2, 5'd5);
    send_op(OP_WRITE, 8'h80, 3'd0, 5'd0);

    program_bases(BaseMax, BaseMax, BaseMax, BaseMax);
    hold_req = 1'b1;
    run_items(PhaseItems, 1'b0);

    program_bases(BaseMin, BaseMin, BaseMin, BaseMin);
    run_items(PhaseItems, 1'b1);

    program_bases($urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 127), $urandom_range(0, 127));
    run_items(PhaseItems, 1'b0);

    program_bases(BaseMax, BaseMin, $urandom_range(0, 127), $urandom_range(0, 127));
    idle_on = 1'b0;
    run_items(PhaseItems / 2, 1'b0);
    idle_on = 1'b1;
    run_items(PhaseItems / 2, 1'b0);

    program_bases(Row0BaseRst, Row1BaseRst, Row2BaseRst, Row3BaseRst);
    idle_on = 1'b0;
    run_items(PhaseItems, 1'b0);

    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d operations, %0d rejected, %0d row wraps, %0d row base settings",
             board.ops, board.rejects, board.wraps, settings);
    $display("%0d bus beats checked, %0d mismatches", board.beats, board.errors);
    if (board.errors == 0) begin
      $display("tb_char_lcd_cursor_controller: clean");
    end else begin
      $display("tb_char_lcd_cursor_controller: errors");
    end
    $finish;
  end

endmodule

>>> files.f
design/lcd_pkg.sv
design/lcd_ifs.sv
design/lcd_front.sv
design/lcd_queue.sv
design/lcd_back.sv
design/char_lcd_cursor_controller.sv
design/lcd_checker.sv
sim/tb_char_lcd_cursor_controller.sv
